[sv/vitk7_pkg.sv]
// Shared types, constants and functions of the K=7 rate one half Viterbi decoder.
package vitk7_pkg;

    localparam int NUM_STATES = 64;
    localparam int STATE_W    = 6;
    localparam int TB_DEPTH   = 64;
    localparam int ROW_W      = 6;
    localparam int METRIC_W   = 24;
    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 7;
    localparam int EXT_W      = 10;
    localparam int SQ_W       = 17;
    localparam int BM_W       = 18;
    localparam int CNT_W      = 6;

    localparam logic [GAIN_W-1:0]   GAIN_RESET = 7'd64;
    localparam logic [STATE_W-1:0]  HIGH_BIT   = 6'h20;
    localparam logic [CNT_W-1:0]    LAST_CNT   = 6'h3f;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_BM,
        ST_ACS,
        ST_DRAIN,
        ST_COMMIT,
        ST_TB,
        ST_TB_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic               load_in;
        logic               sq;
        logic               bm;
        logic               acs_issue;
        logic [STATE_W-1:0] acs_ns;
        logic               commit;
        logic               tb_issue;
        logic               finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_hold;
    } dp_sts_t;

    function automatic logic [1:0] branch_sym(input logic inbit, input logic [STATE_W-1:0] st);
        logic a;
        logic b;
        a = inbit ^ st[1] ^ st[2] ^ st[4] ^ st[5];
        b = inbit ^ st[0] ^ st[1] ^ st[2] ^ st[5];
        return {b, a};
    endfunction

endpackage

[sv/vitk7_ctrl.sv]
// Sequencer that steps the datapath through metric, ACS and traceback phases.
module vitk7_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  vitk7_pkg::dp_sts_t sts,
    output vitk7_pkg::dp_cmd_t cmd
);
    import vitk7_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_BM;
            end
            ST_BM:
            begin
                state_next = ST_ACS;
                cnt_next   = '0;
            end
            ST_ACS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_TB;
                cnt_next   = '0;
            end
            ST_TB:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_TB_DRAIN;
                end
            end
            ST_TB_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_stall     = (state_reg != ST_IDLE);
        cmd.acs_ns   = cnt_reg;
        cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
        cmd.sq       = (state_reg == ST_SQ);
        cmd.bm       = (state_reg == ST_BM);
        cmd.acs_issue = (state_reg == ST_ACS);
        cmd.commit   = (state_reg == ST_COMMIT);
        cmd.tb_issue = (state_reg == ST_TB);
        cmd.finish   = (state_reg == ST_DONE) && !sts.out_hold;
    end

endmodule

[sv/vitk7_dp.sv]
// Datapath: branch metrics, ACS pipeline, metric and survivor memories, traceback.
module vitk7_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vitk7_pkg::dp_cmd_t                 cmd,
    output vitk7_pkg::dp_sts_t                 sts,
    input  logic                               cfg_write,
    input  logic [vitk7_pkg::GAIN_W-1:0]       cfg_data,
    input  logic signed [vitk7_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [vitk7_pkg::SAMPLE_W-1:0] q_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               decoded_bit
);
    import vitk7_pkg::*;

    logic [GAIN_W-1:0]          gain_reg;
    logic signed [SAMPLE_W-1:0] i_reg, q_reg;
    logic [SQ_W-1:0]            sqi_reg [2];
    logic [SQ_W-1:0]            sqq_reg [2];
    logic [BM_W-1:0]            bm_reg [4];

    logic [METRIC_W-1:0]        pm_mem [2*NUM_STATES];
    logic [METRIC_W-1:0]        rd0_reg, rd1_reg;
    logic                       s1_v_reg;
    logic [STATE_W-1:0]         s1_ns_reg;
    logic                       s2_v_reg;
    logic [STATE_W-1:0]         s2_ns_reg;
    logic [METRIC_W-1:0]        s2_metric_reg;
    logic                       s2_dec_reg;
    logic [METRIC_W-1:0]        min_new_reg, min_old_reg;
    logic                       bank_reg, primed_reg;

    logic [NUM_STATES-1:0][STATE_W-1:0] dec_row_reg;
    logic [NUM_STATES-1:0][STATE_W-1:0] surv_mem [TB_DEPTH];
    logic [NUM_STATES-1:0][STATE_W-1:0] row_data_reg;
    logic [TB_DEPTH-1:0]        row_valid_reg;
    logic [ROW_W-1:0]           write_row_reg, tb_row_reg;
    logic                       rv_reg, tb_v_reg;
    logic [STATE_W-1:0]         st_reg;
    logic                       out_valid_reg, out_bit_reg;

    logic signed [EXT_W-1:0]    i_ext, q_ext, g_ext;
    logic signed [EXT_W-1:0]    di0, di1, dq0, dq1;
    logic signed [2*EXT_W-1:0]  pi0, pi1, pq0, pq1;
    logic [STATE_W-1:0]         p0, p1;
    logic [1:0]                 sym0, sym1;
    logic [METRIC_W-1:0]        old0, old1;
    logic [METRIC_W:0]          sum0, sum1;
    logic [METRIC_W-1:0]        d0, d1;

    assign i_ext = EXT_W'(i_reg);
    assign q_ext = EXT_W'(q_reg);
    assign g_ext = signed'({{(EXT_W-GAIN_W){1'b0}}, gain_reg});
    assign di0 = i_ext - g_ext;
    assign di1 = i_ext + g_ext;
    assign dq0 = q_ext - g_ext;
    assign dq1 = q_ext + g_ext;
    assign pi0 = di0 * di0;
    assign pi1 = di1 * di1;
    assign pq0 = dq0 * dq0;
    assign pq1 = dq1 * dq1;

    assign p0   = {1'b0, s1_ns_reg[STATE_W-1:1]};
    assign p1   = p0 | HIGH_BIT;
    assign sym0 = branch_sym(s1_ns_reg[0], p0);
    assign sym1 = branch_sym(s1_ns_reg[0], p1);
    assign old0 = primed_reg ? (rd0_reg - min_old_reg) : '0;
    assign old1 = primed_reg ? (rd1_reg - min_old_reg) : '0;
    assign sum0 = {1'b0, old0} + {{(METRIC_W+1-BM_W){1'b0}}, bm_reg[sym0]};
    assign sum1 = {1'b0, old1} + {{(METRIC_W+1-BM_W){1'b0}}, bm_reg[sym1]};
    assign d0   = sum0[METRIC_W] ? '1 : sum0[METRIC_W-1:0];
    assign d1   = sum1[METRIC_W] ? '1 : sum1[METRIC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            i_reg <= i_sample;
            q_reg <= q_sample;
        end
        if (cmd.sq)
        begin
            sqi_reg[0] <= pi0[SQ_W-1:0];
            sqi_reg[1] <= pi1[SQ_W-1:0];
            sqq_reg[0] <= pq0[SQ_W-1:0];
            sqq_reg[1] <= pq1[SQ_W-1:0];
        end
        if (cmd.bm)
        begin
            for (int k = 0; k < 4; k++)
            begin
                bm_reg[k] <= {1'b0, sqi_reg[k%2]} + {1'b0, sqq_reg[k/2]};
            end
        end
        if (cmd.acs_issue)
        begin
            rd0_reg <= pm_mem[{~bank_reg, 1'b0, cmd.acs_ns[STATE_W-1:1]}];
            rd1_reg <= pm_mem[{~bank_reg, 1'b1, cmd.acs_ns[STATE_W-1:1]}];
            s1_ns_reg <= cmd.acs_ns;
        end
        if (s1_v_reg)
        begin
            s2_ns_reg     <= s1_ns_reg;
            s2_dec_reg    <= !(d0 < d1);
            s2_metric_reg <= (d0 < d1) ? d0 : d1;
        end
        if (s2_v_reg)
        begin
            pm_mem[{bank_reg, s2_ns_reg}] <= s2_metric_reg;
            dec_row_reg[s2_ns_reg] <= {s2_dec_reg, s2_ns_reg[STATE_W-1:1]};
            if ((s2_ns_reg == '0) || (s2_metric_reg < min_new_reg))
            begin
                min_new_reg <= s2_metric_reg;
            end
        end
        if (cmd.commit)
        begin
            surv_mem[write_row_reg] <= dec_row_reg;
        end
        if (cmd.tb_issue)
        begin
            row_data_reg <= surv_mem[tb_row_reg];
        end
        if (cmd.finish)
        begin
            out_bit_reg <= st_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            primed_reg    <= 1'b0;
            min_old_reg   <= '0;
            row_valid_reg <= '0;
            write_row_reg <= '0;
            tb_row_reg    <= '0;
            rv_reg        <= 1'b0;
            tb_v_reg      <= 1'b0;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                gain_reg <= cfg_data;
            end
            s1_v_reg <= cmd.acs_issue;
            s2_v_reg <= s1_v_reg;
            tb_v_reg <= cmd.tb_issue;
            if (cmd.commit)
            begin
                min_old_reg <= min_new_reg;
                bank_reg    <= ~bank_reg;
                primed_reg  <= 1'b1;
                row_valid_reg[write_row_reg] <= 1'b1;
                write_row_reg <= write_row_reg + 1'b1;
                tb_row_reg  <= write_row_reg;
                st_reg      <= '0;
            end
            if (cmd.tb_issue)
            begin
                rv_reg     <= row_valid_reg[tb_row_reg];
                tb_row_reg <= tb_row_reg - 1'b1;
            end
            if (tb_v_reg)
            begin
                st_reg <= rv_reg ? row_data_reg[st_reg] : '0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_hold = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign decoded_bit  = out_bit_reg;

endmodule

[sv/viterbi_decoder_k7_rate_half.sv]
// Top level of the K=7 rate one half soft-decision Viterbi decoder.
//
//   Channel   Direction   Handshake             Payload
//   input     in          in_valid / in_stall   i_sample, q_sample
//   output    out         out_valid / out_stall decoded_bit
//   config    in          cfg_write             cfg_data (gain)
//
// Each word passes through the accept state, the squaring and branch metric setup
// states, ACS for all 64 states through one shared compare unit and a two stage drain,
// a commit, a 64 step traceback through the single survivor memory read port plus a
// drain, and a done state that loads the result into the output register once it is free.
// Reset clears the metric primed flag, survivor row flags and the ring pointer at once.
// A new word is taken while the previous result still waits in the output register.
module viterbi_decoder_k7_rate_half (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [vitk7_pkg::GAIN_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vitk7_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [vitk7_pkg::SAMPLE_W-1:0] q_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  decoded_bit
);
    import vitk7_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    vitk7_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    vitk7_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .i_sample    (i_sample),
        .q_sample    (q_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .decoded_bit (decoded_bit)
    );

endmodule

[sv/vitk7_chk.sv]
// Port-level checker for the Viterbi decoder and its bind statement.
module vitk7_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic decoded_bit
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(decoded_bit)))
        else $error("Stalled output word changed.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall ##2 in_stall))
        else $error("Input taken again too soon.");

    a_result_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("Decoder went idle without a result.");

    a_result_rise_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("Result appeared while decoder busy.");

endmodule

bind viterbi_decoder_k7_rate_half vitk7_chk u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .decoded_bit (decoded_bit)
);
